### hdl/bst_pkg.sv
// shared types and constants of the binary search table unit
package bst_pkg;

	// payload widths fixed by the item format
	localparam int VAL_W = 32;
	localparam int IDX_W = 3;
	localparam int POS_W = 3;

	// entries that a load can reach through its index field
	localparam int ADDR_REACH = 1 << IDX_W;

	// opcodes of an input item
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_en;
		logic start;
		logic step;
		logic finish;
	} bst_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic done;
		logic hit;
	} bst_sts_t;

endpackage

### hdl/bst_if.sv
// request and response channel interfaces of the binary search table unit
interface bst_req_if
	import bst_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic [IDX_W-1:0]        entry_index;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, opcode, entry_index, item_value, input ready);
	modport sink (input valid, opcode, entry_index, item_value, output ready);
endinterface

interface bst_rsp_if
	import bst_pkg::*;
();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;

	modport source (output valid, found, position, input ready);
	modport sink (input valid, found, position, output ready);
endinterface

### hdl/bst_ctrl.sv
// controller state machine of the binary search table unit
module bst_ctrl
	import bst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_opcode,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  bst_sts_t sts,
	output bst_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	// take a new item only between searches
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	// command decode
	always_comb begin
		cmd.load_en = req_valid && req_ready && (req_opcode == OP_LOAD);
		cmd.start   = req_valid && req_ready && (req_opcode == OP_SEARCH);
		cmd.step    = (state_q == ST_SEARCH) && !sts.done;
		cmd.finish  = (state_q == ST_SEARCH) && sts.done && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start)
						state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (cmd.finish)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.finish)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

### hdl/bst_dp.sv
// datapath of the binary search table unit: table, search bounds, result register
module bst_dp
	import bst_pkg::*;
#(
	parameter int TABLE_SIZE = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bst_cmd_t                cmd,
	output bst_sts_t                sts,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic signed [VAL_W-1:0] item_value,
	output logic                    found,
	output logic [POS_W-1:0]        position
);

	// only the first entries are reachable by a load, the rest stay zero
	localparam int NSTORE = (TABLE_SIZE < ADDR_REACH) ? TABLE_SIZE : ADDR_REACH;
	localparam int SIW    = (NSTORE > 1) ? $clog2(NSTORE) : 1;
	// bounds run from 0 to TABLE_SIZE
	localparam int W      = $clog2(TABLE_SIZE + 1);

	logic signed [VAL_W-1:0] table_q [NSTORE];
	logic signed [VAL_W-1:0] key_q;
	logic [W-1:0]            lo_q;
	logic [W-1:0]            hi_p1_q;
	logic                    found_q;
	logic [POS_W-1:0]        position_q;

	logic [W:0]              mid_sum;
	logic [W-1:0]            mid;
	logic signed [VAL_W-1:0] probe;
	logic                    in_range;
	logic                    eq;

	// midpoint of the live range, upper bound kept as hi plus one
	assign in_range = (lo_q < hi_p1_q);
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_p1_q} - {{W{1'b0}}, 1'b1};
	assign mid      = mid_sum[W:1];

	// probe read, entries beyond the stored ones are zero
	always_comb begin
		if (32'(mid) < NSTORE)
			probe = table_q[mid[SIW-1:0]];
		else
			probe = '0;
	end

	assign eq       = (probe == key_q);
	assign sts.hit  = in_range && eq;
	assign sts.done = !in_range || eq;

	// table writes, ignored beyond the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTORE; i++)
				table_q[i] <= '0;
		end else if (cmd.load_en && (32'(entry_index) < TABLE_SIZE)) begin
			table_q[entry_index[SIW-1:0]] <= item_value;
		end
	end

	// search bounds and key
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= item_value;
			lo_q    <= '0;
			hi_p1_q <= W'(TABLE_SIZE);
		end else if (cmd.step) begin
			if (probe > key_q)
				hi_p1_q <= mid;
			else
				lo_q <= mid + {{(W-1){1'b0}}, 1'b1};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q    <= sts.hit;
			position_q <= sts.hit ? POS_W'(mid) : '0;
		end
	end

	assign found    = found_q;
	assign position = position_q;

endmodule

### hdl/binary_search_table_unit.sv
// top level of the binary search table unit
//
// Holds a table of TABLE_SIZE signed 32-bit entries, all zero after reset.
// Items arrive on the req channel (valid/ready). A load item (opcode 0)
// writes item_value at entry_index in the cycle it is accepted and gives
// no result; an index beyond the table leaves the table unchanged.
// A search item (opcode 1) runs a binary search for item_value and gives
// one result on the rsp channel: found and the matching position (zero
// when nothing matched). The table is assumed sorted ascending.
// A search probes one entry per cycle, at most floor(log2(TABLE_SIZE))+1
// probes (four for eight entries). A match ends the search on that probe;
// a miss ends once a further step sees the empty range. The result is
// valid after the edge that ends the search, and req.ready rises with it.
// Loads are taken back to back; req.ready is low while a search runs.
// The result sits in an output register, so a new item is taken while it
// waits. If rsp stalls, a finished search holds until the register frees.
// Reset clears the table, drops rsp.valid and returns to idle.
module binary_search_table_unit
	import bst_pkg::*;
#(
	parameter int TABLE_SIZE = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	bst_req_if.sink   req,
	bst_rsp_if.source rsp
);

	bst_cmd_t cmd;
	bst_sts_t sts;

	// sequencing
	bst_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// table and search datapath
	bst_dp #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.entry_index (req.entry_index),
		.item_value  (req.item_value),
		.found       (rsp.found),
		.position    (rsp.position)
	);

	// at most one command per cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_en, cmd.start, cmd.step, cmd.finish}))
		else $error("more than one datapath command in a cycle");

	// a finished search never overwrites a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !cmd.finish)
		else $error("result overwritten while stalled");

	// starting a search closes the input
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !req.ready)
		else $error("input open right after a search started");

	// a miss reports position zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.position == '0))
		else $error("nonzero position on a miss");

endmodule

### tb/bst_lookup_checker.sv
`timescale 1ns / 1ps
// checker of the binary search table unit: watches both channels, predicts and compares
module bst_lookup_checker
	import bst_pkg::*;
#(
	parameter int TABLE_SIZE = 8
) (
	input  logic clk,
	input  logic arst_n,
	bst_req_if   req,
	bst_rsp_if   rsp,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} lookup_t;

	// shadow copy of the table and the results still owed by the block
	logic signed [VAL_W-1:0] entries [TABLE_SIZE];
	lookup_t                 lookups_due [$];
	int                      errs = 0;

	// binary search over the shadow table, same probe order as the block
	function automatic lookup_t lookup(input logic signed [VAL_W-1:0] key);
		int      lo;
		int      hi;
		int      mid;
		lookup_t hit;
		lo  = 0;
		hi  = TABLE_SIZE - 1;
		hit = '0;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (entries[mid] == key) begin
				hit.found    = 1'b1;
				hit.position = mid[POS_W-1:0];
				return hit;
			end
			if (entries[mid] > key)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return hit;
	endfunction

	// track accepted items on both channels
	always @(posedge clk or negedge arst_n) begin
		lookup_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				entries[i] = '0;
			lookups_due.delete();
			mismatches <= errs;
			pending    <= 0;
		end else begin
			// results leave first: they belong to searches taken earlier
			if (rsp.valid && rsp.ready) begin
				if (lookups_due.size() == 0) begin
					$display("%0t: result with none expected, actual found=%0b position=%0d",
						$time, rsp.found, rsp.position);
					errs++;
				end else begin
					want = lookups_due.pop_front();
					if (rsp.found !== want.found) begin
						$display("%0t: found mismatch, expected %0b actual %0b",
							$time, want.found, rsp.found);
						errs++;
					end
					if (rsp.position !== want.position) begin
						$display("%0t: position mismatch, expected %0d actual %0d",
							$time, want.position, rsp.position);
						errs++;
					end
				end
			end
			// loads update the shadow table, searches queue an expectation
			if (req.valid && req.ready) begin
				if (req.opcode == OP_LOAD) begin
					if (req.entry_index < TABLE_SIZE)
						entries[req.entry_index] = req.item_value;
				end else begin
					lookups_due.push_back(lookup(req.item_value));
				end
			end
			mismatches <= errs;
			pending    <= lookups_due.size();
		end
	end

endmodule

### tb/tb_binary_search_table_unit.sv
`timescale 1ns / 1ps
// testbench top of the binary search table unit: clock, reset, stimulus and verdict
module tb_binary_search_table_unit;
	import bst_pkg::*;

	localparam int TABLE_SIZE = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD = 300;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_cnt;
	int   pending;
	int   cycle_cnt = 0;

	// knobs for the receiver process, written with nonblocking assignments
	int   rx_stall_pct;
	logic long_hold_req;
	int   hold_left;
	logic hold_used;

	// knobs and bookkeeping of the sender
	int   tx_idle_pct;
	int   sent = 0;

	bst_req_if req_ch ();
	bst_rsp_if rsp_ch ();

	binary_search_table_unit #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	bst_lookup_checker #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.mismatches(fail_cnt),
		.pending   (pending)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_used    <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (long_hold_req && !hold_used) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= LONG_HOLD;
			hold_used    <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// offer one item after a random gap and wait until it is taken
	task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
		input logic signed [VAL_W-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.entry_index <= idx;
		req_ch.item_value  <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// stop offering and wait until every owed result has come out
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// load a fresh table, mostly sorted, then search it
	task automatic run_table_set(input int n_search);
		logic signed [VAL_W-1:0] vals [TABLE_SIZE];
		longint                  v;
		int                      mode;
		int                      step_max;
		int                      k;
		logic                    rev;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] key;
		mode = $urandom_range(3);
		case (mode)
			0: step_max = 2;
			1: step_max = 1000;
			default: step_max = 32'h1000_0000;
		endcase
		v = ($urandom_range(3) == 0) ? -64'sd2147483648 : longint'(int'($urandom));
		for (int i = 0; i < TABLE_SIZE; i++) begin
			// unsorted noise table now and then
			if (mode == 3)
				vals[i] = $urandom;
			else begin
				vals[i] = v[VAL_W-1:0];
				v = v + longint'($urandom_range(step_max));
				if (v > 64'sd2147483647)
					v = 64'sd2147483647;
			end
		end
		rev = 1'($urandom_range(1));
		for (int i = 0; i < TABLE_SIZE; i++) begin
			k = rev ? TABLE_SIZE - 1 - i : i;
			send_item(OP_LOAD, k[IDX_W-1:0], vals[k]);
		end
		for (int n = 0; n < n_search; n++) begin
			idx = IDX_W'($urandom_range(TABLE_SIZE - 1));
			k   = $urandom_range(99);
			if (k < 8) begin
				// stray load in the middle of the searches
				send_item(OP_LOAD, idx, $urandom);
				continue;
			end
			if (k < 60)
				key = vals[$urandom_range(TABLE_SIZE - 1)];
			else if (k < 80)
				key = vals[$urandom_range(TABLE_SIZE - 1)] + ($urandom_range(1) ? 1 : -1);
			else
				key = $urandom;
			send_item(OP_SEARCH, idx, key);
		end
	endtask

	// stimulus
	initial begin
		logic signed [VAL_W-1:0] corner [TABLE_SIZE];
		int tx_pct_of [4];
		int rx_pct_of [4];
		int goal;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.opcode      = OP_LOAD;
		req_ch.entry_index = '0;
		req_ch.item_value  = '0;
		tx_idle_pct        = 0;
		rx_stall_pct       = 0;
		long_hold_req      = 1'b0;
		corner    = '{32'sh8000_0000, -32'sd100, -32'sd1, 32'sd0,
			32'sd1, 32'sd100, 32'sd1000, 32'sh7fff_ffff};
		tx_pct_of = '{0, 57, 0, 14};
		rx_pct_of = '{0, 0, 57, 14};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// searches of the all-zero table left by reset
		send_item(OP_SEARCH, 3'd5, 32'sd0);
		send_item(OP_SEARCH, 3'd0, 32'sd1);
		send_item(OP_SEARCH, 3'd7, -32'sd1);
		// table spanning the whole value range
		for (int i = 0; i < TABLE_SIZE; i++)
			send_item(OP_LOAD, i[IDX_W-1:0], corner[i]);
		send_item(OP_SEARCH, 3'd0, 32'sh8000_0000);
		send_item(OP_SEARCH, 3'd7, 32'sh7fff_ffff);
		send_item(OP_SEARCH, 3'd2, 32'sd100);
		send_item(OP_SEARCH, 3'd3, 32'sd50);
		send_item(OP_SEARCH, 3'd4, -32'sd50);
		send_item(OP_SEARCH, 3'd6, 32'sd0);
		// duplicate entries: the first probed match wins
		send_item(OP_LOAD, 3'd4, 32'sd0);
		send_item(OP_SEARCH, 3'd1, 32'sd0);
		// unsorted table: the probe path misses an entry that is present
		send_item(OP_LOAD, 3'd6, -32'sd5);
		send_item(OP_SEARCH, 3'd7, -32'sd5);
		wait_drained();

		// random phases with different idling on each side
		goal = sent;
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = tx_pct_of[ph];
			rx_stall_pct  <= rx_pct_of[ph];
			long_hold_req <= (ph == 0);
			goal += 345;
			while (sent < goal)
				run_table_set($urandom_range(8, 24));
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
hdl/bst_pkg.sv
hdl/bst_if.sv
hdl/bst_ctrl.sv
hdl/bst_dp.sv
hdl/binary_search_table_unit.sv
tb/bst_lookup_checker.sv
tb/tb_binary_search_table_unit.sv
